// ===== src/kmct_pkg.sv =====
// Package for the keyed match count table: request and result types,
// opcodes, the cell chain carry and the update command.
// Used by every module of the block; depends on nothing.
package kmct_pkg;

	localparam int TABLE_ENTRIES_DEF = 64;
	localparam int KEY_BITS_DEF      = 64;
	localparam int COUNT_BITS        = 32;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	localparam logic [1:0] OP_LOOKUP = 2'd0;
	localparam logic [1:0] OP_INC    = 2'd1;
	localparam logic [1:0] OP_DEC    = 2'd2;
	localparam logic [1:0] OP_NOP    = 2'd3;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [63:0] key;
		logic        selected;
	} request_t;

	typedef struct packed {
		logic                  found;
		logic [COUNT_BITS-1:0] previous_count;
		logic [COUNT_BITS-1:0] current_count;
		logic                  became_matched;
		logic                  became_unmatched;
		logic                  table_full;
	} result_t;

	typedef struct packed {
		logic                  active;
		logic                  hit;
		logic [COUNT_BITS-1:0] count;
		logic                  free_seen;
	} carry_t;

	typedef struct packed {
		logic                  upd;
		logic                  del;
		logic                  ins;
		logic [COUNT_BITS-1:0] cnt;
	} apply_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

// ===== src/keyed_match_count_table.sv =====
// Keyed match count table: up to TABLE_ENTRIES keys, each with a match count.
// Each request (opcode, key, selected) enters on the request channel and gives
// exactly one result (found, previous and current count, transition flags and
// table_full) on the result channel. Both channels use valid and stall; an
// item moves at an edge with valid high and stall low.
// The entries sit in a chain of cells. A scan token walks the chain one cell
// per cycle, collecting the matching count and the lowest free entry, so
// result_valid rises only once the token has left the last cell; the length
// of the chain sets how long a scan takes. The table takes no new request
// until the last one's result has gone to the output register.
// A new request is taken the cycle after the controller hands its result to
// the output register, even while that result is still stalled; a result held
// by a stall keeps the next request from finishing until the receiver takes it.
// Reset clears every entry's valid bit at once, so the table starts empty and
// the first request can be taken in the first cycle after reset.
module keyed_match_count_table #(
	parameter int TABLE_ENTRIES = kmct_pkg::TABLE_ENTRIES_DEF,
	parameter int KEY_BITS      = kmct_pkg::KEY_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  request_valid,
	output logic                  request_stall,
	input  kmct_pkg::request_t    request,
	output logic                  result_valid,
	input  logic                  result_stall,
	output kmct_pkg::result_t     result
);

	logic [KEY_BITS-1:0]  key_bcast;
	kmct_pkg::carry_t     chain [TABLE_ENTRIES+1];
	kmct_pkg::apply_t     apply;

	kmct_ctrl #(
		.KEY_BITS(KEY_BITS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.request_valid(request_valid),
		.request_stall(request_stall),
		.request      (request),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.key_bcast    (key_bcast),
		.head         (chain[0]),
		.tail         (chain[TABLE_ENTRIES]),
		.apply        (apply)
	);

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		kmct_cell #(
			.KEY_BITS(KEY_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.key      (key_bcast),
			.carry_in (chain[i]),
			.carry_out(chain[i+1]),
			.apply    (apply)
		);
	end

endmodule

// ===== src/kmct_cell.sv =====
// One entry of the keyed match count table and its stage of the scan chain.
// Depends on kmct_pkg for the carry and update command types.
module kmct_cell #(
	parameter int KEY_BITS = kmct_pkg::KEY_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [KEY_BITS-1:0]   key,
	input  kmct_pkg::carry_t      carry_in,
	output kmct_pkg::carry_t      carry_out,
	input  kmct_pkg::apply_t      apply
);

	logic                                valid_q;
	logic [KEY_BITS-1:0]                 key_q;
	logic [kmct_pkg::COUNT_BITS-1:0]     count_q;
	logic                                match_q;
	logic                                first_free_q;
	logic                                match;
	kmct_pkg::carry_t                    carry_d;
	kmct_pkg::carry_t                    carry_q;

	always_comb begin
		match             = valid_q && (key_q == key);
		carry_d.active    = carry_in.active;
		carry_d.hit       = carry_in.hit | match;
		carry_d.count     = match ? count_q : carry_in.count;
		carry_d.free_seen = carry_in.free_seen | !valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q      <= '0;
			match_q      <= 1'b0;
			first_free_q <= 1'b0;
			valid_q      <= 1'b0;
		end else begin
			carry_q <= carry_d;
			if (carry_in.active) begin
				match_q      <= match;
				first_free_q <= !valid_q && !carry_in.free_seen;
			end
			if (apply.del && match_q) begin
				valid_q <= 1'b0;
			end else if (apply.ins && first_free_q) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (apply.upd && match_q) begin
			count_q <= apply.cnt;
		end else if (apply.ins && first_free_q) begin
			key_q   <= key;
			count_q <= kmct_pkg::COUNT_BITS'(1);
		end
	end

	assign carry_out = carry_q;

endmodule

// ===== src/kmct_ctrl.sv =====
// Controller of the keyed match count table: takes a request, runs the scan
// down the cell chain, forms the result and sends the update to the cells.
// Depends on kmct_pkg.
module kmct_ctrl #(
	parameter int KEY_BITS = kmct_pkg::KEY_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  request_valid,
	output logic                  request_stall,
	input  kmct_pkg::request_t    request,
	output logic                  result_valid,
	input  logic                  result_stall,
	output kmct_pkg::result_t     result,
	output logic [KEY_BITS-1:0]   key_bcast,
	output kmct_pkg::carry_t      head,
	input  kmct_pkg::carry_t      tail,
	output kmct_pkg::apply_t      apply
);

	kmct_pkg::state_t                state_q;
	kmct_pkg::state_t                state_d;
	kmct_pkg::request_t              req_q;
	kmct_pkg::result_t               res_q;
	kmct_pkg::result_t               res_d;
	kmct_pkg::apply_t                apl_d;
	logic                            res_vld_q;
	logic                            head_act_q;
	logic                            hit_q;
	logic                            free_q;
	logic [kmct_pkg::COUNT_BITS-1:0] cnt_q;
	logic                            accept;
	logic                            fire;

	assign accept = request_valid && (state_q == kmct_pkg::ST_IDLE);
	assign fire   = (state_q == kmct_pkg::ST_DONE) && (!res_vld_q || !result_stall);

	always_comb begin
		res_d = '0;
		apl_d = '0;
		unique case (req_q.opcode)
			kmct_pkg::OP_LOOKUP: begin
				res_d.found          = hit_q && req_q.selected;
				res_d.previous_count = res_d.found ? cnt_q : '0;
				res_d.current_count  = res_d.previous_count;
			end
			kmct_pkg::OP_NOP: begin
				res_d.found          = hit_q;
				res_d.previous_count = hit_q ? cnt_q : '0;
				res_d.current_count  = res_d.previous_count;
			end
			kmct_pkg::OP_INC: begin
				if (hit_q) begin
					res_d.found          = 1'b1;
					res_d.previous_count = cnt_q;
					res_d.current_count  = (cnt_q == kmct_pkg::COUNT_MAX) ?
						kmct_pkg::COUNT_MAX : cnt_q + kmct_pkg::COUNT_BITS'(1);
					apl_d.upd            = 1'b1;
					apl_d.cnt            = res_d.current_count;
				end else if (free_q) begin
					res_d.current_count  = kmct_pkg::COUNT_BITS'(1);
					res_d.became_matched = 1'b1;
					apl_d.ins            = 1'b1;
				end else begin
					res_d.table_full = 1'b1;
				end
			end
			kmct_pkg::OP_DEC: begin
				if (hit_q) begin
					res_d.found          = 1'b1;
					res_d.previous_count = cnt_q;
					res_d.current_count  = (cnt_q == '0) ?
						'0 : cnt_q - kmct_pkg::COUNT_BITS'(1);
					if (res_d.current_count == '0) begin
						apl_d.del              = 1'b1;
						res_d.became_unmatched = (cnt_q != '0);
					end else begin
						apl_d.upd = 1'b1;
						apl_d.cnt = res_d.current_count;
					end
				end
			end
			default: begin
				res_d = '0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			kmct_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = kmct_pkg::ST_SCAN;
				end
			end
			kmct_pkg::ST_SCAN: begin
				if (tail.active) begin
					state_d = kmct_pkg::ST_DONE;
				end
			end
			kmct_pkg::ST_DONE: begin
				if (fire) begin
					state_d = kmct_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = kmct_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= kmct_pkg::ST_IDLE;
			head_act_q <= 1'b0;
			res_vld_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			head_act_q <= accept;
			if (fire) begin
				res_vld_q <= 1'b1;
			end else if (!result_stall) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= request;
		end
		if (tail.active) begin
			hit_q  <= tail.hit;
			cnt_q  <= tail.count;
			free_q <= tail.free_seen;
		end
		if (fire) begin
			res_q <= res_d;
		end
	end

	always_comb begin
		head           = '0;
		head.active    = head_act_q;
		apply          = fire ? apl_d : '0;
	end

	assign request_stall = (state_q != kmct_pkg::ST_IDLE);
	assign result_valid  = res_vld_q;
	assign result        = res_q;
	assign key_bcast     = req_q.key[KEY_BITS-1:0];

`ifndef ASSERT_OFF
	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		request_valid && !request_stall |=> state_q == kmct_pkg::ST_SCAN)
		else $error("Accepted request did not start a scan.");
	a_tail_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tail.active |-> state_q == kmct_pkg::ST_SCAN)
		else $error("Scan token reached the controller outside a scan.");
	a_apply_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({apply.upd, apply.del, apply.ins}))
		else $error("More than one table update issued at once.");
	a_apply_done: assert property (@(posedge clk) disable iff (!arst_n)
		(apply.upd || apply.del || apply.ins) |=> state_q == kmct_pkg::ST_IDLE && result_valid)
		else $error("Table update without a delivered result.");
	a_matched_one: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.became_matched |->
		result.current_count == kmct_pkg::COUNT_BITS'(1) && !result.found)
		else $error("New entry reported with a wrong count.");
`endif

endmodule

// ===== tb/tb.sv =====
// Testbench for keyed_match_count_table: directed and random requests with a
// built-in match table predictor and a result checker under random stalls.
// Depends on kmct_pkg and keyed_match_count_table from src.
`timescale 1ns / 100ps

module tb;

	localparam int TABLE_ENTRIES = 64;
	localparam int KEY_BITS      = 64;
	localparam int POOL_SIZE     = 128;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam logic [63:0] KEY_MASK = {64{1'b1}} >> (64 - KEY_BITS);
	localparam logic [63:0] KEY_ONES = {64{1'b1}};

	logic               clk = 1'b0;
	logic               arst_n;
	logic               request_valid;
	logic               request_stall;
	kmct_pkg::request_t request;
	logic               result_valid;
	logic               result_stall;
	kmct_pkg::result_t  result;

	logic                            table_valid [TABLE_ENTRIES];
	logic [63:0]                     table_key   [TABLE_ENTRIES];
	logic [kmct_pkg::COUNT_BITS-1:0] table_count [TABLE_ENTRIES];
	logic [63:0]                     key_pool    [POOL_SIZE];
	kmct_pkg::result_t               pending_results[$];

	int send_idle_pct;
	int recv_idle_pct;
	int errors;
	int cycles;

	keyed_match_count_table #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.KEY_BITS(KEY_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.request_valid(request_valid),
		.request_stall(request_stall),
		.request(request),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("keyed_match_count_table test failed");
			$finish;
		end
	end

	function automatic kmct_pkg::result_t update_match_table(input kmct_pkg::request_t req);
		kmct_pkg::result_t r;
		int                hit;
		int                slot;
		int                i;
		logic [63:0]       k;
		r = '0;
		hit = -1;
		slot = -1;
		k = req.key & KEY_MASK;
		for (i = 0; i < TABLE_ENTRIES; i++) begin
			if (hit < 0 && table_valid[i] && table_key[i] == k)
				hit = i;
			if (slot < 0 && !table_valid[i])
				slot = i;
		end
		unique case (req.opcode)
			kmct_pkg::OP_LOOKUP, kmct_pkg::OP_NOP: begin
				if (hit >= 0 && (req.opcode == kmct_pkg::OP_NOP || req.selected)) begin
					r.found = 1'b1;
					r.previous_count = table_count[hit];
					r.current_count = table_count[hit];
				end
			end
			kmct_pkg::OP_INC: begin
				if (hit >= 0) begin
					r.found = 1'b1;
					r.previous_count = table_count[hit];
					r.current_count = (table_count[hit] == kmct_pkg::COUNT_MAX) ?
						kmct_pkg::COUNT_MAX : table_count[hit] + 1'b1;
					table_count[hit] = r.current_count;
				end else if (slot >= 0) begin
					table_valid[slot] = 1'b1;
					table_key[slot] = k;
					table_count[slot] = kmct_pkg::COUNT_BITS'(1);
					r.current_count = kmct_pkg::COUNT_BITS'(1);
					r.became_matched = 1'b1;
				end else begin
					r.table_full = 1'b1;
				end
			end
			kmct_pkg::OP_DEC: begin
				if (hit >= 0) begin
					r.found = 1'b1;
					r.previous_count = table_count[hit];
					r.current_count = (table_count[hit] == 0) ? '0 : table_count[hit] - 1'b1;
					if (r.current_count == 0) begin
						table_valid[hit] = 1'b0;
						table_count[hit] = '0;
						r.became_unmatched = (r.previous_count != 0);
					end else begin
						table_count[hit] = r.current_count;
					end
				end
			end
		endcase
		return r;
	endfunction

	task automatic send_request(input logic [1:0] opcode, input logic [63:0] key,
			input logic selected);
		kmct_pkg::request_t req;
		req.opcode = opcode;
		req.key = key;
		req.selected = selected;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			request_valid <= 1'b0;
			@(negedge clk);
		end
		request_valid <= 1'b1;
		request <= req;
		do
			@(posedge clk);
		while (request_stall);
		pending_results.insert(pending_results.size(), update_match_table(req));
	endtask

	always @(negedge clk)
		result_stall <= ($urandom_range(99) < recv_idle_pct);

	task automatic check_result(input kmct_pkg::result_t got);
		kmct_pkg::result_t want;
		if (pending_results.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual %h", $time, got);
			errors++;
		end else begin
			want = pending_results.pop_front();
			if (want !== got) begin
				$display("%0t: result mismatch, expected %h, actual %h", $time, want, got);
				errors++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			check_result(result);
	end

	task automatic test_empty_table();
		send_request(kmct_pkg::OP_LOOKUP, 64'd0, 1'b1);
		send_request(kmct_pkg::OP_LOOKUP, KEY_ONES, 1'b0);
		send_request(kmct_pkg::OP_NOP, 64'd0, 1'b0);
		send_request(kmct_pkg::OP_DEC, 64'd5, 1'b1);
	endtask

	task automatic test_key_lifecycle();
		send_request(kmct_pkg::OP_INC, KEY_ONES, 1'b0);
		send_request(kmct_pkg::OP_INC, KEY_ONES, 1'b1);
		send_request(kmct_pkg::OP_INC, 64'd0, 1'b1);
		send_request(kmct_pkg::OP_LOOKUP, KEY_ONES, 1'b1);
		send_request(kmct_pkg::OP_LOOKUP, KEY_ONES, 1'b0);
		send_request(kmct_pkg::OP_NOP, KEY_ONES, 1'b0);
		send_request(kmct_pkg::OP_NOP, 64'd0, 1'b1);
		send_request(kmct_pkg::OP_DEC, KEY_ONES, 1'b1);
		send_request(kmct_pkg::OP_DEC, KEY_ONES, 1'b0);
		send_request(kmct_pkg::OP_LOOKUP, KEY_ONES, 1'b1);
		send_request(kmct_pkg::OP_DEC, 64'd0, 1'b1);
		send_request(kmct_pkg::OP_INC, 64'h8000_0000_0000_0000, 1'b0);
		send_request(kmct_pkg::OP_INC, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
		send_request(kmct_pkg::OP_INC, 64'h5555_5555_5555_5555, 1'b0);
		send_request(kmct_pkg::OP_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAB, 1'b1);
		send_request(kmct_pkg::OP_LOOKUP, 64'h5555_5555_5555_5555, 1'b1);
		send_request(kmct_pkg::OP_DEC, 64'h8000_0000_0000_0000, 1'b1);
		send_request(kmct_pkg::OP_DEC, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
		send_request(kmct_pkg::OP_DEC, 64'h5555_5555_5555_5555, 1'b1);
	endtask

	task automatic test_random_traffic(input int send_pct, input int recv_pct,
			input int count);
		int          i;
		int          pick;
		bit          filling;
		logic [1:0]  opcode;
		logic [63:0] key;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (i = 0; i < POOL_SIZE / 2; i++)
			key_pool[i] = {$urandom, $urandom};
		for (i = POOL_SIZE / 2; i < POOL_SIZE; i++)
			key_pool[i] = key_pool[i - POOL_SIZE / 2] ^ (64'd1 << $urandom_range(63));
		for (i = 0; i < count; i++) begin
			filling = (i < count / 2);
			pick = $urandom_range(99);
			if (filling)
				opcode = (pick < 60) ? kmct_pkg::OP_INC : (pick < 75) ? kmct_pkg::OP_DEC :
					(pick < 90) ? kmct_pkg::OP_LOOKUP : kmct_pkg::OP_NOP;
			else
				opcode = (pick < 15) ? kmct_pkg::OP_INC : (pick < 70) ? kmct_pkg::OP_DEC :
					(pick < 88) ? kmct_pkg::OP_LOOKUP : kmct_pkg::OP_NOP;
			if ($urandom_range(99) < 5)
				key = {$urandom, $urandom};
			else
				key = key_pool[$urandom_range(POOL_SIZE - 1)];
			send_request(opcode, key, 1'($urandom_range(1)));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		request_valid = 1'b0;
		request = '0;
		result_stall = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		errors = 0;
		cycles = 0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			table_valid[i] = 1'b0;
			table_key[i] = '0;
			table_count[i] = '0;
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		send_idle_pct = 37;
		recv_idle_pct = 71;
		test_empty_table();
		test_key_lifecycle();
		test_random_traffic(37, 71, 584);
		test_random_traffic(71, 37, 584);
		test_random_traffic(0, 0, 584);
		@(negedge clk);
		request_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TABLE_ENTRIES + 16) @(posedge clk);
		if (errors == 0)
			$display("keyed_match_count_table test passed");
		else
			$display("keyed_match_count_table test failed");
		$finish;
	end

endmodule
